// ===== src/lea_pkg.sv =====
// Shared types, constants and helper functions of the LEA-128 counter-mode generator.
package lea_pkg;

    localparam int LEA_ROUNDS  = 24;
    localparam int LEA_WORDS   = 4;
    localparam int LEA_KEY_REGS = 4;
    localparam int LEA_CFG_AW  = 2;
    // Depth of the queue between the front and the back; must be a power of two.
    localparam int LEA_Q_DEPTH = 2;

    typedef logic [LEA_WORDS-1:0][31:0] t_blk;

    // Operation codes carried on the input tuser.
    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_DIRECT   = 1'b1
    } t_op;

    localparam logic [31:0] LEA_DELTA [4] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
    };

    localparam logic [4:0] LEA_KS_ROT [4] = '{5'd1, 5'd3, 5'd6, 5'd11};

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] w;
        w = {x, x} << r;
        return w[63:32];
    endfunction

endpackage

// ===== src/lea128_counter_mode_generator.sv =====
// Top level of the LEA-128 counter-mode block generator.
// The block encrypts one 128-bit block per transaction with LEA-128 and returns
// the four ciphertext words. With tuser low it encrypts {counter low word,
// counter high word, 0, 0} and then increments the 64-bit wrapping counter; with
// tuser high it encrypts the block on tdata and leaves the counter alone. A
// write of any key word clears the counter and restarts the round-key schedule,
// which produces one round key per cycle; the same sweep runs after reset for
// the all-zero key. During the sweep the input is not ready. Otherwise, while
// the output is not stalled, the block accepts a transaction in every cycle and
// delivers one result per cycle: a request lands in a two-entry queue and the
// first round cell loads straight from the queue head at the next edge, and the
// result then passes through a chain of ROUNDS registered round cells. A stall
// on the output freezes the round chain while the queue still takes up to two
// more requests.
module lea128_counter_mode_generator #(
    parameter int ROUNDS = lea_pkg::LEA_ROUNDS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration writes: register index 0..3 selects key_word0..key_word3.
    input  logic          i_cfg_we,
    input  logic [lea_pkg::LEA_CFG_AW-1:0] i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata,
    // Request stream.
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tdata, from bit 0 up: plain_word0, plain_word1, plain_word2, plain_word3.
    input  logic [127:0]  i_s_axis_tdata,
    // tuser: operation (0 generate from counter, 1 encrypt tdata).
    input  logic          i_s_axis_tuser,
    // Result stream.
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // tdata, from bit 0 up: cipher_word0, cipher_word1, cipher_word2, cipher_word3.
    output logic [127:0]  o_m_axis_tdata
);
    import lea_pkg::*;

    t_blk w_rk [ROUNDS];
    t_blk w_q_blk;
    t_blk w_out;
    logic w_busy;
    logic w_q_valid;
    logic w_q_pop;

    // Key registers and round-key sweep.
    lea_ksched #(.ROUNDS(ROUNDS)) u_ksched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (w_busy),
        .o_rk        (w_rk)
    );

    // The front builds the block to encrypt and queues it; the counter is
    // cleared on every key write.
    lea_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cfg_we),
        .i_hold    (w_busy),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op      (i_s_axis_tuser),
        .i_plain   (t_blk'(i_s_axis_tdata)),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_blk   (w_q_blk)
    );

    // The back runs the rounds; its last stage drives the result stream.
    lea_back #(.ROUNDS(ROUNDS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_q_pop),
        .i_blk   (w_q_blk),
        .i_rk    (w_rk),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_blk   (w_out)
    );

    assign o_m_axis_tdata = w_out;

endmodule

// ===== src/lea_ksched.sv =====
// Key registers and the round-key schedule, one round key produced per cycle.
module lea_ksched #(
    parameter int ROUNDS = lea_pkg::LEA_ROUNDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lea_pkg::LEA_CFG_AW-1:0] i_cfg_idx,
    input  logic [31:0]                 i_cfg_wdata,
    output logic                        o_busy,
    output lea_pkg::t_blk               o_rk [ROUNDS]
);
    import lea_pkg::*;

    localparam int IDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    t_blk             r_key;
    t_blk             r_t;
    t_blk             n_t;
    t_blk             w_key;
    t_blk             r_rk [ROUNDS];
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic [31:0]      w_delta;

    // Key as it stands after the write in this cycle.
    always_comb begin
        w_key = r_key;
        w_key[i_cfg_idx] = i_cfg_wdata;
    end

    always_comb begin
        w_delta = LEA_DELTA[2'(r_idx)];
        for (int j = 0; j < LEA_WORDS; j++) begin
            n_t[j] = rotl32(r_t[j] + rotl32(w_delta, 5'(r_idx) + 5'(j)), LEA_KS_ROT[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_t    <= '0;
            r_idx  <= '0;
            r_busy <= 1'b1;
        end else if (i_cfg_we) begin
            r_key  <= w_key;
            r_t    <= w_key;
            r_idx  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_t <= n_t;
            if (r_idx == IDX_W'(ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_we) begin
            r_rk[r_idx] <= n_t;
        end
    end

    assign o_busy = r_busy;
    assign o_rk   = r_rk;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IDX_W'(ROUNDS - 1)))
        else $error("key schedule index past last round");

endmodule

// ===== src/lea_front.sv =====
// Input side: accepts requests, builds the plaintext block, keeps the counter, queues blocks.
module lea_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_hold,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  lea_pkg::t_blk i_plain,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output lea_pkg::t_blk o_q_blk
);
    import lea_pkg::*;

    localparam int Q_AW = (LEA_Q_DEPTH > 1) ? $clog2(LEA_Q_DEPTH) : 1;

    t_blk            r_q [LEA_Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic [63:0]     r_ctr;
    t_blk            w_blk;
    logic            w_push;
    logic            w_pop;

    assign o_ready   = (r_cnt < (Q_AW+1)'(LEA_Q_DEPTH)) && !i_hold;
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_blk   = r_q[r_rp];

    always_comb begin
        if (t_op'(i_op) == OP_DIRECT) begin
            w_blk = i_plain;
        end else begin
            w_blk = {32'd0, 32'd0, r_ctr[63:32], r_ctr[31:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ctr <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
            if (i_clr) begin
                r_ctr <= '0;
            end else if (w_push && t_op'(i_op) == OP_GENERATE) begin
                r_ctr <= r_ctr + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_blk;
        end
    end

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(LEA_Q_DEPTH))
        else $error("request queue overfilled");

    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && t_op'(i_op) == OP_GENERATE && !i_clr) |=> (r_ctr == $past(r_ctr) + 64'd1))
        else $error("counter did not advance on generate request");

endmodule

// ===== src/lea_round.sv =====
// One LEA encryption round.
module lea_round (
    input  lea_pkg::t_blk i_x,
    input  lea_pkg::t_blk i_rk,
    output lea_pkg::t_blk o_x
);
    import lea_pkg::*;

    always_comb begin
        o_x[0] = rotl32((i_x[0] ^ i_rk[0]) + (i_x[1] ^ i_rk[1]), 5'd9);
        o_x[1] = rotl32((i_x[1] ^ i_rk[2]) + (i_x[2] ^ i_rk[1]), 5'd27);
        o_x[2] = rotl32((i_x[2] ^ i_rk[3]) + (i_x[3] ^ i_rk[1]), 5'd29);
        o_x[3] = i_x[0];
    end

endmodule

// ===== src/lea_back.sv =====
// Cipher side: a chain of registered round cells, the last stage being the output register.
module lea_back #(
    parameter int ROUNDS = lea_pkg::LEA_ROUNDS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  lea_pkg::t_blk i_blk,
    input  lea_pkg::t_blk i_rk [ROUNDS],
    output logic          o_valid,
    input  logic          i_ready,
    output lea_pkg::t_blk o_blk
);
    import lea_pkg::*;

    logic [ROUNDS-1:0] r_vld;
    t_blk              r_x [ROUNDS];
    t_blk              w_nx [ROUNDS];
    logic              w_en;

    // The chain moves whenever the output register is empty or being drained.
    assign w_en    = !r_vld[ROUNDS-1] || i_ready;
    assign o_pop   = w_en;
    assign o_valid = r_vld[ROUNDS-1];
    assign o_blk   = r_x[ROUNDS-1];

    for (genvar k = 0; k < ROUNDS; k++) begin : g_rnd
        if (k == 0) begin : g_first
            lea_round u_round (.i_x(i_blk), .i_rk(i_rk[k]), .o_x(w_nx[k]));
        end else begin : g_next
            lea_round u_round (.i_x(r_x[k-1]), .i_rk(i_rk[k]), .o_x(w_nx[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < ROUNDS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < ROUNDS; k++) begin
                r_x[k] <= w_nx[k];
            end
        end
    end

    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("round chain moved while stalled");

endmodule
